### rtl/voxel_face_cull_ao_mesher_core_defines.svh
// ----------------------------------------------------------------------------
// Voxel mesher assertion macros
// Shared assertion shorthands for the voxel mesher checker.
// ----------------------------------------------------------------------------
`ifndef VOXEL_FACE_CULL_AO_MESHER_CORE_DEFINES_SVH
`define VOXEL_FACE_CULL_AO_MESHER_CORE_DEFINES_SVH

// implication checked on every clock edge outside reset
`define VFCM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// same, with the consequent checked in the cycle after the antecedent
`define VFCM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/vfcm_pkg.sv
// ----------------------------------------------------------------------------
// Voxel mesher package
// Shared constants, types and neighbor lookup functions.
// ----------------------------------------------------------------------------
package vfcm_pkg;

	localparam int EDGE_LEN_DEF = 32;
	localparam int VTX_W        = 20;
	localparam int COORD_W      = 7;
	localparam int VOX_W        = 8;
	localparam int NBR_N        = 27;
	localparam int NBR_W        = 5;
	localparam logic [NBR_W-1:0] CENTER_IDX = 5'd13;

	typedef enum logic [1:0] {
		ACT_WRITE = 2'd0,
		ACT_READ  = 2'd1,
		ACT_CLEAR = 2'd2,
		ACT_MESH  = 2'd3
	} act_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD_WAIT,
		ST_GATHER,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	// neighborhood index of the voxel across face f
	function automatic logic [NBR_W-1:0] face_nbr_idx(input logic [2:0] f);
		logic [NBR_W-1:0] r;
		case (f)
			3'd0:    r = 5'd16;
			3'd1:    r = 5'd10;
			3'd2:    r = 5'd22;
			3'd3:    r = 5'd4;
			3'd4:    r = 5'd12;
			3'd5:    r = 5'd14;
			default: r = CENTER_IDX;
		endcase
		return r;
	endfunction

	function automatic logic [NBR_W-1:0] nbr_idx(input int q0, input int q1, input int q2);
		return NBR_W'((q0 + 1) + 3 * (q1 + 1) + 9 * (q2 + 1));
	endfunction

	// occlusion level of one quad corner from the 3x3x3 solid map
	function automatic logic [1:0] corner_ao(input logic [NBR_N-1:0] s,
	                                         input logic [2:0] f, input logic [1:0] v);
		int a1;
		int a2;
		int d1;
		int d2;
		int q1 [3];
		int q2 [3];
		int qc [3];
		logic s1;
		logic s2;
		logic c;
		logic [1:0] r;
		case (f[2:1])
			2'd0:    begin a1 = 0; a2 = 2; end
			2'd1:    begin a1 = 0; a2 = 1; end
			default: begin a1 = 1; a2 = 2; end
		endcase
		if (f[2:1] == 2'd2) begin
			d1 = (v[1]) ? 1 : -1;
			d2 = (v == 2'd1 || v == 2'd2) ? 1 : -1;
		end else begin
			d1 = (v == 2'd1 || v == 2'd2) ? 1 : -1;
			d2 = (v[1]) ? 1 : -1;
		end
		for (int i = 0; i < 3; i++) begin
			q1[i] = 0;
			q2[i] = 0;
			qc[i] = 0;
		end
		q1[a1] = d1;
		q2[a2] = d2;
		qc[a1] = d1;
		qc[a2] = d2;
		s1 = s[nbr_idx(q1[0], q1[1], q1[2])];
		s2 = s[nbr_idx(q2[0], q2[1], q2[2])];
		c  = s[nbr_idx(qc[0], qc[1], qc[2])];
		if (s1 && s2)
			r = 2'd0;
		else
			r = 2'd3 - {1'b0, s1} - {1'b0, s2} - {1'b0, c};
		return r;
	endfunction

endpackage

### rtl/voxel_face_cull_ao_mesher_core.sv
// ----------------------------------------------------------------------------
// Voxel face culling mesher with corner occlusion
// Voxel cube in one single-port RAM; meshes one voxel into visible face quads.
// ----------------------------------------------------------------------------
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_ready  | action, pos_x, pos_y, pos_z, block_value
//  out     | out_valid/ out_ready | kind, read_value, face, ao_corner0..3,
//          |                      | base_vertex, last
//
//  Write and clear: done at accept. Read: accept, then RD_WAIT until the output
//  register is free. Mesh: accept, GATHER walking the 27 cells of the 3x3x3
//  neighborhood through the one RAM port, DRAIN, then EMIT over the 6 faces;
//  a visible face waits there until the output register is free.
//  After reset a clearing pass zeroes all 2^(3*clog2(EDGE_LEN)) RAM words, one word a cycle
//  (32768 at the default), with in_ready low.
//
module voxel_face_cull_ao_mesher_core #(
	parameter int EDGE_LEN = vfcm_pkg::EDGE_LEN_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    action,
	input  logic signed [vfcm_pkg::COORD_W-1:0] pos_x,
	input  logic signed [vfcm_pkg::COORD_W-1:0] pos_y,
	input  logic signed [vfcm_pkg::COORD_W-1:0] pos_z,
	input  logic [vfcm_pkg::VOX_W-1:0]    block_value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          kind,
	output logic [vfcm_pkg::VOX_W-1:0]    read_value,
	output logic [2:0]                    face,
	output logic [1:0]                    ao_corner0,
	output logic [1:0]                    ao_corner1,
	output logic [1:0]                    ao_corner2,
	output logic [1:0]                    ao_corner3,
	output logic [vfcm_pkg::VTX_W-1:0]    base_vertex,
	output logic                          last
);

	// per-axis address bits; RAM address is {z, y, x}
	localparam int AW    = (EDGE_LEN > 1) ? $clog2(EDGE_LEN) : 1;
	localparam int RAM_AW = 3 * AW;
	localparam int DEPTH = 1 << RAM_AW;
	localparam logic [7:0] EDGE_C = 8'(EDGE_LEN);

	vfcm_pkg::state_t state_q, state_d;

	logic [RAM_AW-1:0] clr_q;
	logic signed [vfcm_pkg::COORD_W-1:0] px_q, py_q, pz_q;
	logic [1:0] ox_q, oy_q, oz_q;
	logic [vfcm_pkg::NBR_W-1:0] k_q;
	logic [vfcm_pkg::NBR_N-1:0] solid_q;
	logic g_vld_s1, g_inr_s1;
	logic [vfcm_pkg::NBR_W-1:0] g_idx_s1;
	logic rd_inr_q;
	logic [2:0] f_q;
	logic [vfcm_pkg::VTX_W-1:0] vtx_q;

	// address generation
	logic signed [vfcm_pkg::COORD_W-1:0] src_x, src_y, src_z;
	logic [1:0] sx, sy, sz;
	logic [7:0] cx, cy, cz;
	logic inr;
	logic [RAM_AW-1:0] vox_addr;

	// RAM port
	logic ram_en, ram_we;
	logic [RAM_AW-1:0] ram_addr;
	logic [vfcm_pkg::VOX_W-1:0] ram_wdata, ram_rdata;

	// face emission
	logic [5:0] vis_mask;
	logic more_vis;
	logic out_free;
	logic acc;
	logic ld_read, ld_face;

	assign in_ready = (state_q == vfcm_pkg::ST_IDLE);
	assign acc      = in_valid && in_ready;
	assign out_free = !out_valid || out_ready;

	always_comb begin
		if (state_q == vfcm_pkg::ST_GATHER) begin
			src_x = px_q; src_y = py_q; src_z = pz_q;
			sx = ox_q; sy = oy_q; sz = oz_q;
		end else begin
			src_x = pos_x; src_y = pos_y; src_z = pos_z;
			sx = 2'd1; sy = 2'd1; sz = 2'd1;
		end
		cx = {src_x[vfcm_pkg::COORD_W-1], src_x} + {6'd0, sx} - 8'd1;
		cy = {src_y[vfcm_pkg::COORD_W-1], src_y} + {6'd0, sy} - 8'd1;
		cz = {src_z[vfcm_pkg::COORD_W-1], src_z} + {6'd0, sz} - 8'd1;
		inr = !cx[7] && (cx < EDGE_C) && !cy[7] && (cy < EDGE_C)
		      && !cz[7] && (cz < EDGE_C);
		vox_addr = {cz[AW-1:0], cy[AW-1:0], cx[AW-1:0]};
	end

	// RAM control: clearing sweep, direct write/read at accept, neighborhood walk
	always_comb begin
		ram_en    = 1'b0;
		ram_we    = 1'b0;
		ram_addr  = vox_addr;
		ram_wdata = block_value;
		unique case (state_q)
			vfcm_pkg::ST_CLEAR: begin
				ram_en    = 1'b1;
				ram_we    = 1'b1;
				ram_addr  = clr_q;
				ram_wdata = '0;
			end
			vfcm_pkg::ST_IDLE: begin
				if (acc && (action == vfcm_pkg::ACT_WRITE || action == vfcm_pkg::ACT_READ)) begin
					ram_en = inr;
					ram_we = (action == vfcm_pkg::ACT_WRITE);
				end
			end
			vfcm_pkg::ST_GATHER: begin
				ram_en = inr;
			end
			default: begin
			end
		endcase
	end

	vfcm_ram #(
		.WIDTH(vfcm_pkg::VOX_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// visible faces: solid center and empty neighbor across the face
	always_comb begin
		for (int i = 0; i < 6; i++)
			vis_mask[i] = solid_q[vfcm_pkg::CENTER_IDX]
			              && !solid_q[vfcm_pkg::face_nbr_idx(3'(i))];
		more_vis = 1'b0;
		for (int i = 0; i < 6; i++)
			if (3'(i) > f_q && vis_mask[i])
				more_vis = 1'b1;
	end

	// next state
	always_comb begin
		state_d = state_q;
		ld_read = 1'b0;
		ld_face = 1'b0;
		unique case (state_q)
			vfcm_pkg::ST_CLEAR: begin
				if (&clr_q)
					state_d = vfcm_pkg::ST_IDLE;
			end
			vfcm_pkg::ST_IDLE: begin
				if (acc) begin
					if (action == vfcm_pkg::ACT_READ)
						state_d = vfcm_pkg::ST_RD_WAIT;
					else if (action == vfcm_pkg::ACT_MESH)
						state_d = vfcm_pkg::ST_GATHER;
				end
			end
			vfcm_pkg::ST_RD_WAIT: begin
				if (out_free) begin
					ld_read = 1'b1;
					state_d = vfcm_pkg::ST_IDLE;
				end
			end
			vfcm_pkg::ST_GATHER: begin
				if (k_q == 5'(vfcm_pkg::NBR_N - 1))
					state_d = vfcm_pkg::ST_DRAIN;
			end
			vfcm_pkg::ST_DRAIN: begin
				state_d = vfcm_pkg::ST_EMIT;
			end
			vfcm_pkg::ST_EMIT: begin
				ld_face = vis_mask[f_q] && out_free;
				if ((!vis_mask[f_q] || out_free) && f_q == 3'd5)
					state_d = vfcm_pkg::ST_IDLE;
			end
			default: state_d = vfcm_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= vfcm_pkg::ST_CLEAR;
		else
			state_q <= state_d;
	end

	// control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q    <= '0;
			ox_q     <= '0;
			oy_q     <= '0;
			oz_q     <= '0;
			k_q      <= '0;
			f_q      <= '0;
			g_vld_s1 <= 1'b0;
			vtx_q    <= '0;
		end else begin
			g_vld_s1 <= (state_q == vfcm_pkg::ST_GATHER);
			if (state_q == vfcm_pkg::ST_CLEAR)
				clr_q <= clr_q + 1'b1;
			if (acc && action == vfcm_pkg::ACT_CLEAR)
				vtx_q <= '0;
			if (acc) begin
				ox_q <= '0;
				oy_q <= '0;
				oz_q <= '0;
				k_q  <= '0;
			end
			if (state_q == vfcm_pkg::ST_GATHER) begin
				k_q <= k_q + 1'b1;
				if (ox_q == 2'd2) begin
					ox_q <= '0;
					if (oy_q == 2'd2) begin
						oy_q <= '0;
						oz_q <= oz_q + 1'b1;
					end else begin
						oy_q <= oy_q + 1'b1;
					end
				end else begin
					ox_q <= ox_q + 1'b1;
				end
			end
			if (state_q == vfcm_pkg::ST_DRAIN)
				f_q <= '0;
			else if (state_q == vfcm_pkg::ST_EMIT && (!vis_mask[f_q] || out_free))
				f_q <= f_q + 1'b1;
			if (ld_face)
				vtx_q <= vtx_q + 20'd4;
		end
	end

	// request payload and gathered neighborhood
	always_ff @(posedge clk) begin
		if (acc) begin
			px_q     <= pos_x;
			py_q     <= pos_y;
			pz_q     <= pos_z;
			rd_inr_q <= inr;
		end
		g_idx_s1 <= k_q;
		g_inr_s1 <= inr;
		if (g_vld_s1)
			solid_q[g_idx_s1] <= g_inr_s1 && (ram_rdata != '0);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (ld_read || ld_face)
			out_valid <= 1'b1;
		else if (out_ready)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ld_read) begin
			kind        <= 1'b0;
			read_value  <= rd_inr_q ? ram_rdata : '0;
			face        <= '0;
			ao_corner0  <= '0;
			ao_corner1  <= '0;
			ao_corner2  <= '0;
			ao_corner3  <= '0;
			base_vertex <= '0;
			last        <= 1'b1;
		end else if (ld_face) begin
			kind        <= 1'b1;
			read_value  <= '0;
			face        <= f_q;
			ao_corner0  <= vfcm_pkg::corner_ao(solid_q, f_q, 2'd0);
			ao_corner1  <= vfcm_pkg::corner_ao(solid_q, f_q, 2'd1);
			ao_corner2  <= vfcm_pkg::corner_ao(solid_q, f_q, 2'd2);
			ao_corner3  <= vfcm_pkg::corner_ao(solid_q, f_q, 2'd3);
			base_vertex <= vtx_q;
			last        <= !more_vis;
		end
	end

endmodule

### rtl/vfcm_ram.sv
// ----------------------------------------------------------------------------
// Voxel mesher RAM
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module vfcm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32768
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we)
				mem[addr] <= wdata;
			else
				rdata <= mem[addr];
		end
	end

endmodule

### rtl/vfcm_chk.sv
// ----------------------------------------------------------------------------
// Voxel mesher port checker
// Port-level assertions, bound to the mesher top level.
// ----------------------------------------------------------------------------
`include "voxel_face_cull_ao_mesher_core_defines.svh"

module vfcm_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        kind,
	input logic [7:0]  read_value,
	input logic [2:0]  face,
	input logic [19:0] base_vertex,
	input logic        last
);

	`VFCM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(face) && $stable(base_vertex), "stalled result changed")
	`VFCM_ASSERT(a_read_shape, out_valid && !kind |-> last && face == 3'd0 && base_vertex == 20'd0, "malformed read result")
	`VFCM_ASSERT(a_face_shape, out_valid && kind |-> read_value == 8'd0 && face <= 3'd5, "malformed face result")
	`VFCM_ASSERT(a_busy_mid_mesh, out_valid && kind && !last |-> !in_ready, "request taken before mesh finished")

endmodule

bind voxel_face_cull_ao_mesher_core vfcm_chk u_vfcm_chk (.*);
